[sv/pfc_pkg.sv]
// shared types, constants and the per-byte scan step of the video frame counter
package pfc_pkg;

    localparam int COUNT_BITS_DEF = 24;

    localparam int WIN_LEN = 10;
    localparam int AVAIL_W = 4;
    localparam logic [AVAIL_W-1:0] WIN_FULL = 4'd10;
    localparam logic [AVAIL_W-1:0] FLUSH_START = 4'd9;
    localparam logic [AVAIL_W-1:0] PREFIX_MIN = 4'd4;
    localparam logic [AVAIL_W-1:0] PREFIX_HDR_MIN = 4'd5;

    localparam int PKT_W = 17;
    localparam int HDR_W = 9;
    localparam int PSKIP_W = 3;

    localparam logic [7:0] CODE_ZERO = 8'h00;
    localparam logic [7:0] CODE_ONE = 8'h01;
    localparam logic [7:0] VIDEO_STREAM_ID = 8'hE0;
    localparam logic [PKT_W-1:0] PES_LEN_EXTRA = 17'd5;
    localparam logic [HDR_W-1:0] PES_HDR_FIXED = 9'd8;
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [PSKIP_W-1:0] PREFIX3_LEN = 3'd3;
    localparam logic [PSKIP_W-1:0] PREFIX4_LEN = 3'd4;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_START_TICKS = 1'b0;
    localparam logic REG_FRAME_TICKS = 1'b1;
    localparam logic [31:0] START_TICKS_RST = 32'd0;
    localparam logic [15:0] FRAME_TICKS_RST = 16'd3003;

    typedef logic [WIN_LEN-1:0][7:0] window_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'b01,
        PH_PACKET = 2'b10
    } phase_t;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_FLUSH = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_SUM   = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        phase_t             phase;
        logic [PKT_W-1:0]   packet_left;
        logic [HDR_W-1:0]   header_left;
        logic [PSKIP_W-1:0] prefix_left;
    } scan_t;

    typedef struct packed {
        scan_t scan;
        logic  hit;
    } judge_t;

    localparam scan_t SCAN_RST = '{
        phase: PH_SEARCH,
        packet_left: '0,
        header_left: '0,
        prefix_left: '0
    };

    // one step of the scanner on the oldest window byte, avail bytes known up to stream end
    function automatic judge_t judge_byte(scan_t cur, window_t w, logic [AVAIL_W-1:0] avail);
        judge_t             res;
        logic [PSKIP_W-1:0] plen;
        logic [4:0]         nal;
        res = '{scan: cur, hit: 1'b0};
        plen = '0;
        nal = '0;
        if (cur.phase == PH_SEARCH) begin
            if (avail >= WIN_FULL && w[0] == CODE_ZERO && w[1] == CODE_ZERO &&
                w[2] == CODE_ONE && w[3] == VIDEO_STREAM_ID) begin
                res.scan.packet_left = PKT_W'({w[4], w[5]}) + PES_LEN_EXTRA;
                res.scan.header_left = HDR_W'(w[8]) + PES_HDR_FIXED;
                res.scan.prefix_left = '0;
                res.scan.phase = PH_PACKET;
            end
        end else begin
            if (cur.header_left != '0) begin
                res.scan.header_left = cur.header_left - HDR_W'(1);
            end else if (cur.prefix_left != '0) begin
                res.scan.prefix_left = cur.prefix_left - PSKIP_W'(1);
            end else if (cur.packet_left >= PKT_W'(PREFIX_MIN) && avail >= PREFIX_MIN &&
                         w[0] == CODE_ZERO && w[1] == CODE_ZERO) begin
                if (w[2] == CODE_ONE) begin
                    plen = PREFIX3_LEN;
                    nal = w[3][4:0];
                end else if (w[2] == CODE_ZERO && w[3] == CODE_ONE) begin
                    plen = PREFIX4_LEN;
                    if (cur.packet_left >= PKT_W'(PREFIX_HDR_MIN) && avail >= PREFIX_HDR_MIN) begin
                        nal = w[4][4:0];
                    end
                end
                if (plen != '0) begin
                    res.hit = (nal == NAL_SLICE) || (nal == NAL_IDR);
                    res.scan.prefix_left = plen;
                end
            end
            res.scan.packet_left = cur.packet_left - PKT_W'(1);
            if (res.scan.packet_left == '0) begin
                res.scan.phase = PH_SEARCH;
                res.scan.header_left = '0;
                res.scan.prefix_left = '0;
            end
        end
        return res;
    endfunction

endpackage

[sv/pes_h264_frame_counter_top.sv]
// video frame counter for a program stream: scans video packets for slice NAL prefixes
// The block takes one stream byte per cycle while s_ready is high and holds the last ten
// bytes in a window; each byte is judged once nine later bytes are in, so a video packet
// start (00 00 01 E0) is seen with its length and header length at hand, and the payload is
// scanned for 00 00 01 and 00 00 00 01 prefixes whose NAL type is 1 or 5. After the byte
// marked last, s_ready drops while the up to nine held bytes are judged one per cycle; the
// flush stops once no packet is open. Then ST_MUL forms the count times frame_ticks product
// and ST_SUM does the add and saturation; the result then goes to an output register and
// the next stream may start while it waits to be taken. The stream end is held up longer
// while an earlier result still waits in the output register.
// start_ticks sits at address 0 and frame_ticks at address 4; write them only while idle.
module pes_h264_frame_counter_top
    import pfc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic [23:0]           m_frame_count,
    output logic [31:0]           m_total_ticks,
    output logic                  m_found,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PROD_W = COUNT_BITS + 16;
    localparam int SUM_W = ((PROD_W > 32) ? PROD_W : 32) + 1;

    logic [31:0]            start_ticks_reg;
    logic [15:0]            frame_ticks_reg;

    ctrl_state_t            state_reg, state_next;
    scan_t                  scan_reg, scan_next;
    window_t                win_reg, win_next;
    logic [AVAIL_W-1:0]     fill_reg, fill_next;
    logic [AVAIL_W-1:0]     avail_reg, avail_next;
    logic [COUNT_BITS-1:0]  frames_reg, frames_next;
    logic [PROD_W-1:0]      prod_reg;

    logic [23:0]            frame_count_reg;
    logic [31:0]            duration_reg;
    logic                   found_reg;
    logic                   m_valid_reg;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_load;
    window_t                win_shift;
    window_t                win_flush;
    logic [AVAIL_W-1:0]     fill_inc;
    window_t                judge_win;
    logic [AVAIL_W-1:0]     judge_avail;
    judge_t                 jres;
    logic                   do_judge;
    logic [SUM_W-1:0]       dur_sum;
    logic [31:0]            dur_sat;
    logic [COUNT_BITS+23:0] frames_ext;

    // config port
    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ticks_reg <= START_TICKS_RST;
            frame_ticks_reg <= FRAME_TICKS_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_START_TICKS: start_ticks_reg <= pwdata;
                REG_FRAME_TICKS: frame_ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_TICKS: prdata = start_ticks_reg;
            REG_FRAME_TICKS: prdata = {16'b0, frame_ticks_reg};
            default:         prdata = '0;
        endcase
    end

    // byte scan
    assign s_ready = (state_reg == ST_RUN);
    assign in_accept = s_valid & s_ready;
    assign win_shift = {s_data_byte, win_reg[WIN_LEN-1:1]};
    assign win_flush = {CODE_ZERO, win_reg[WIN_LEN-1:1]};
    assign fill_inc = (fill_reg == WIN_FULL) ? WIN_FULL : fill_reg + AVAIL_W'(1);
    assign judge_win = (state_reg == ST_RUN) ? win_shift : win_flush;
    assign judge_avail = (state_reg == ST_RUN) ? WIN_FULL : avail_reg;
    assign jres = judge_byte(scan_reg, judge_win, judge_avail);

    // result stage
    assign dur_sum = SUM_W'(prod_reg) + SUM_W'(start_ticks_reg);
    assign dur_sat = (dur_sum[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : dur_sum[31:0];
    assign frames_ext = {24'b0, frames_reg};
    assign out_load = (state_reg == ST_SUM) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        scan_next = scan_reg;
        win_next = win_reg;
        fill_next = fill_reg;
        avail_next = avail_reg;
        frames_next = frames_reg;
        do_judge = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                if (in_accept) begin
                    win_next = win_shift;
                    fill_next = fill_inc;
                    do_judge = (fill_inc == WIN_FULL);
                    if (s_last_byte) begin
                        avail_next = FLUSH_START;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (scan_reg.phase == PH_SEARCH || avail_reg == '0) begin
                    state_next = ST_MUL;
                end else begin
                    win_next = win_flush;
                    do_judge = (avail_reg <= fill_reg);
                    avail_next = avail_reg - AVAIL_W'(1);
                end
            end
            ST_MUL: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (out_load) begin
                    scan_next = SCAN_RST;
                    fill_next = '0;
                    frames_next = '0;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
        if (do_judge) begin
            scan_next = jres.scan;
            if (jres.hit && frames_reg != '1) begin
                frames_next = frames_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            scan_reg <= SCAN_RST;
            fill_reg <= '0;
            avail_reg <= '0;
            frames_reg <= '0;
        end else begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            fill_reg <= fill_next;
            avail_reg <= avail_next;
            frames_reg <= frames_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(frames_reg) * PROD_W'(frame_ticks_reg);
        end
        if (out_load) begin
            frame_count_reg <= frames_ext[23:0];
            found_reg <= (frames_reg != '0);
            duration_reg <= (frames_reg != '0) ? dur_sat : 32'd0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_frame_count = frame_count_reg;
    assign m_total_ticks = duration_reg;
    assign m_found = found_reg;

endmodule

[tb/sv/tb_pes_h264_frame_counter_top.sv]
// self-checking testbench for the program stream video frame counter: directed and random streams
module tb_pes_h264_frame_counter_top;
    import pfc_pkg::*;

    typedef struct packed {
        logic [23:0] frame_count;
        logic [31:0] total_ticks;
        logic        found;
    } count_result_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        count_result_t result;
    } stim_row_t;

    localparam longint unsigned SLICES_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
    localparam logic [7:0] SID_AUDIO = 8'hC0;
    localparam logic [7:0] SID_PACK = 8'hBA;
    localparam logic [7:0] SID_PRIVATE = 8'hBD;
    localparam logic [7:0] SID_VIDEO_ALT = 8'hE1;
    localparam count_result_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 26;
    localparam int SETTING_COUNT = 6;

    // one video packet: 3-byte prefix of type 5, then a 4-byte prefix cut off by the stream end
    // after that a nine byte stream, too short for any packet start
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'hE0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h0B, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h65, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, 1'b1, '{24'd1, 32'd3003, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'hE0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{24'd0, 32'd0, 1'b0}}
    };

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic [7:0]            s_data_byte = '0;
    logic                  s_last_byte = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [23:0]           m_frame_count;
    logic [31:0]           m_total_ticks;
    logic                  m_found;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    pes_h264_frame_counter_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_frame_count(m_frame_count),
        .m_total_ticks(m_total_ticks),
        .m_found(m_found),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic [7:0]      win_bytes [WIN_LEN];
    int unsigned     win_count;
    phase_t          pred_phase;
    int unsigned     pkt_remaining;
    int unsigned     hdr_remaining;
    int unsigned     skip_remaining;
    longint unsigned slices_counted;
    logic [31:0]     start_ticks_cfg;
    logic [15:0]     frame_ticks_cfg;

    count_result_t expected_counts [$];
    count_result_t head_result;
    logic [7:0]    stream_bytes [$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  streams_sent = 0;
    int  found_seen = 0;
    int  settings_used = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("[pes_h264_frame_counter_top] ERROR");
        $finish;
    end

    function automatic void clear_scan();
        int k;
        for (k = 0; k < WIN_LEN; k++) win_bytes[k] = 8'h00;
        win_count = 0;
        pred_phase = PH_SEARCH;
        pkt_remaining = 0;
        hdr_remaining = 0;
        skip_remaining = 0;
        slices_counted = 0;
    endfunction

    function automatic void judge_window_byte(int s, int avail);
        logic [7:0]  w [WIN_LEN];
        int unsigned plen;
        logic [4:0]  nal;
        int          k;
        for (k = 0; k < WIN_LEN; k++) w[k] = (s + k < WIN_LEN) ? win_bytes[s + k] : 8'h00;
        plen = 0;
        nal = '0;
        if (pred_phase == PH_SEARCH) begin
            if (avail >= WIN_LEN && w[0] == CODE_ZERO && w[1] == CODE_ZERO &&
                w[2] == CODE_ONE && w[3] == VIDEO_STREAM_ID) begin
                pkt_remaining = 5 + {w[4], w[5]};
                hdr_remaining = 8 + w[8];
                skip_remaining = 0;
                pred_phase = PH_PACKET;
            end
            return;
        end
        if (hdr_remaining > 0) begin
            hdr_remaining--;
        end else if (skip_remaining > 0) begin
            skip_remaining--;
        end else if (pkt_remaining >= 4 && avail >= 4 && w[0] == CODE_ZERO &&
                     w[1] == CODE_ZERO) begin
            if (w[2] == CODE_ONE) begin
                plen = 3;
                nal = w[3][4:0];
            end else if (w[2] == CODE_ZERO && w[3] == CODE_ONE) begin
                plen = 4;
                if (pkt_remaining >= 5 && avail >= 5) nal = w[4][4:0];
            end
            if (plen != 0) begin
                if ((nal == NAL_SLICE || nal == NAL_IDR) && slices_counted < SLICES_MAX)
                    slices_counted++;
                skip_remaining = plen;
            end
        end
        pkt_remaining--;
        if (pkt_remaining == 0) begin
            pred_phase = PH_SEARCH;
            hdr_remaining = 0;
            skip_remaining = 0;
        end
    endfunction

    function automatic bit predict_count(input logic [7:0] b, input bit last,
                                         output count_result_t r);
        int              k;
        longint unsigned dur;
        r = NO_RESULT;
        for (k = 0; k < WIN_LEN - 1; k++) win_bytes[k] = win_bytes[k + 1];
        win_bytes[WIN_LEN - 1] = b;
        if (win_count < WIN_LEN) win_count++;
        if (win_count == WIN_LEN) judge_window_byte(0, WIN_LEN);
        if (!last) return 1'b0;
        // held bytes are judged with the stream end known
        for (k = (win_count == WIN_LEN) ? 1 : WIN_LEN - win_count; k < WIN_LEN; k++)
            judge_window_byte(k, WIN_LEN - k);
        dur = 0;
        if (slices_counted > 0) begin
            dur = start_ticks_cfg + slices_counted * frame_ticks_cfg;
            if (dur > 64'hFFFF_FFFF) dur = 64'hFFFF_FFFF;
        end
        r.frame_count = slices_counted[23:0];
        r.total_ticks = dur[31:0];
        r.found = (slices_counted > 0);
        clear_scan();
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        return ($urandom_range(0, 2) == 0) ? CODE_ZERO : 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_video_packet();
        logic [7:0]  body [$];
        int          hdr;
        int          k;
        logic [15:0] len;
        logic [4:0]  nal;
        logic [2:0]  upper;
        hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) body.push_back(CODE_ZERO);
            body.push_back(CODE_ZERO);
            body.push_back(CODE_ZERO);
            body.push_back(CODE_ONE);
            if ($urandom_range(0, 1)) nal = $urandom_range(0, 1) ? NAL_SLICE : NAL_IDR;
            else nal = 5'($urandom_range(0, 31));
            upper = 3'($urandom_range(0, 7));
            body.push_back({upper, nal});
            repeat ($urandom_range(0, 4)) body.push_back(noise_byte());
        end
        len = 16'(3 + hdr + body.size());
        // broken length: short, long or anything at all
        if ($urandom_range(0, 6) == 0)
            len = $urandom_range(0, 1) ? 16'($urandom_range(0, len + 6)) :
                                         16'($urandom_range(0, 65535));
        stream_bytes.push_back(CODE_ZERO);
        stream_bytes.push_back(CODE_ZERO);
        stream_bytes.push_back(CODE_ONE);
        stream_bytes.push_back(VIDEO_STREAM_ID);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[7:0]);
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        stream_bytes.push_back(8'(hdr));
        repeat (hdr) stream_bytes.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < body.size(); k++) stream_bytes.push_back(body[k]);
    endfunction

    function automatic void add_other_packet();
        logic [7:0] sid;
        case ($urandom_range(0, 3))
            0: sid = SID_AUDIO;
            1: sid = SID_PACK;
            2: sid = SID_PRIVATE;
            default: sid = SID_VIDEO_ALT;
        endcase
        stream_bytes.push_back(CODE_ZERO);
        stream_bytes.push_back(CODE_ZERO);
        stream_bytes.push_back(CODE_ONE);
        stream_bytes.push_back(sid);
        repeat ($urandom_range(2, 8)) stream_bytes.push_back(noise_byte());
    endfunction

    function automatic void build_stream();
        int keep;
        stream_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 9)) stream_bytes.push_back(noise_byte());
            return;
        end
        repeat ($urandom_range(0, 4)) stream_bytes.push_back(noise_byte());
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 4) == 0) add_other_packet();
            else add_video_packet();
            repeat ($urandom_range(0, 2)) stream_bytes.push_back(noise_byte());
        end
        // stream cut short somewhere
        if ($urandom_range(0, 5) == 0) begin
            keep = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input bit last, input bit typed,
                             input count_result_t typed_res);
        int            gap;
        count_result_t r;
        gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (predict_count(d, last, r)) begin
            expected_counts.push_back(typed ? typed_res : r);
            streams_sent++;
        end
    endtask

    task automatic tx_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (wr && idx == REG_START_TICKS) start_ticks_cfg = wdata;
        else if (wr) frame_ticks_cfg = wdata[15:0];
    endtask

    task automatic apply_settings(input logic [31:0] st, input logic [15:0] ft);
        logic [31:0] rd;
        tx_idle();
        wait_drained();
        repeat (16) @(posedge aclk);
        apb_access(1'b1, REG_START_TICKS, st, rd);
        apb_access(1'b1, REG_FRAME_TICKS, {16'h0000, ft}, rd);
        apb_access(1'b0, REG_START_TICKS, '0, rd);
        check_field("start_ticks readback", start_ticks_cfg, rd);
        apb_access(1'b0, REG_FRAME_TICKS, '0, rd);
        check_field("frame_ticks readback", {16'h0000, frame_ticks_cfg}, rd);
        settings_used++;
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            if ($urandom_range(0, 3) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_found === 1'b1) found_seen++;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result count %0d ticks %0d found %0d", $time,
                         m_frame_count, m_total_ticks, m_found);
                mismatches++;
            end else begin
                head_result = expected_counts.pop_front();
                check_field("frame_count", 32'(head_result.frame_count), 32'(m_frame_count));
                check_field("total_ticks", head_result.total_ticks, m_total_ticks);
                check_field("found", 32'(head_result.found), 32'(m_found));
            end
        end
    end

    initial begin : stimulus
        int          p;
        int          i;
        logic [31:0] st_list [SETTING_COUNT];
        logic [15:0] ft_list [SETTING_COUNT];
        st_list = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_E000, $urandom, 32'h0};
        ft_list = '{16'hFFFF, 16'h0, 16'd1, 16'd3003, 16'($urandom_range(0, 65535)), 16'hFFFF};
        clear_scan();
        start_ticks_cfg = START_TICKS_RST;
        frame_ticks_cfg = FRAME_TICKS_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed,
                      DIRECTED[i].result);

        for (p = 0; p < SETTING_COUNT; p++) begin
            apply_settings(st_list[p], ft_list[p]);
            while (bytes_sent < DIRECTED_ROWS + (p + 1) * 221) begin
                build_stream();
                if ($urandom_range(0, 5) == 0) begin
                    tx_idle();
                    wait_drained();
                end
                tx_steady = ($urandom_range(0, 3) == 0);
                for (i = 0; i < stream_bytes.size(); i++)
                    send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, NO_RESULT);
            end
        end

        tx_idle();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d stream bytes in %0d streams, %0d with frames found, %0d settings",
                 bytes_sent, streams_sent, found_seen, settings_used);
        if (mismatches == 0) begin
            $display("[pes_h264_frame_counter_top] OK");
        end else begin
            $display("[pes_h264_frame_counter_top] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/pfc_pkg.sv
sv/pes_h264_frame_counter_top.sv
tb/sv/tb_pes_h264_frame_counter_top.sv
